[design/prime_filter_average_macros.svh]
// ----------------------------------------------------------------------------
// prime_filter_average assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PRIME_FILTER_AVERAGE_MACROS_SVH
`define PRIME_FILTER_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PFA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prime_filter_average: assertion failed");
// next-cycle implication
`define PFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prime_filter_average: assertion failed");
`else
`define PFA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PFA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[design/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared widths and sequencer state type for prime_filter_average.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int SUM_W  = 27;              // running sum of primes
  localparam int CNT_W  = 11;              // running count of primes
  localparam int FRAC_W = 8;               // fraction bits of the mean
  localparam int AVG_W  = 24;              // mean, 16.8 fixed point
  localparam int MEAN_W = SUM_W + FRAC_W;  // dividend width of the mean

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TRIAL,
    ST_ACCUM,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_DONE
  } pfa_state_t;

endpackage

[design/prime_filter_average.sv]
// ----------------------------------------------------------------------------
// prime_filter_average
// Streaming primality test by trial division, with the mean of the primes.
//
// Input channel (in_valid / in_stall): value and is_last. in_stall is high
// while an item is being worked on; one item at a time is taken.
// Output channel (out_valid / out_stall): one result item per input item.
// Each item tries the trial divisors 2..floor(sqrt(value)) in turn, one
// division each, until one divides; a last item then also divides the sum
// by the count for the mean.
// All divisions run through the one shared bit-serial divider.
// The output register frees the input side: a new item is accepted while a
// result waits; a stalled result holds until taken, and a finished item
// then waits for the output register before the next item is accepted.
// Reset clears the sum, count and overflow flag and empties the output.
// ----------------------------------------------------------------------------
`include "prime_filter_average_macros.svh"

module prime_filter_average #(
  parameter int VALUE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [VALUE_BITS-1:0]   value,
  input  logic                    is_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    is_prime,
  output logic                    average_valid,
  output logic [pfa_pkg::AVG_W-1:0] average,
  output logic                    no_primes,
  output logic                    saturated
);

  import pfa_pkg::*;

  localparam int TD_W  = VALUE_BITS / 2 + 1;          // trial divisor
  localparam int SQ_W  = VALUE_BITS + 2;              // divisor squared
  localparam int DV_W  = (TD_W > CNT_W) ? TD_W : CNT_W;
  localparam int PAD_W = MEAN_W - VALUE_BITS;
  localparam int ST_W  = $clog2(MEAN_W + 1);
  localparam int SE_W  = ((VALUE_BITS > SUM_W) ? VALUE_BITS : SUM_W) + 1;
  localparam logic [SE_W-1:0] SUM_LIM = {{(SE_W-SUM_W){1'b0}}, {SUM_W{1'b1}}};

  pfa_state_t state, state_next;

  logic [VALUE_BITS-1:0] x;
  logic                  last_r;
  logic [TD_W-1:0]       d;
  logic [SQ_W-1:0]       sq;
  logic                  prime_r;
  logic [SUM_W-1:0]      sum;
  logic [CNT_W-1:0]      count;
  logic                  ovf;
  logic [AVG_W-1:0]      avg_r;
  logic                  nop_r;

  logic                  div_start;
  logic                  div_mean;
  logic [MEAN_W-1:0]     div_dividend;
  logic [DV_W-1:0]       div_divisor;
  logic [ST_W-1:0]       div_steps;
  logic                  div_done;
  logic [MEAN_W-1:0]     div_quo;
  logic [DV_W-1:0]       div_rem;

  logic                  x_small;
  logic                  trial_end;
  logic                  out_free;
  logic [SE_W-1:0]       sum_wide;
  logic                  sum_over;
  logic                  count_full;

  always_comb begin
    div_mean     = (state == ST_MEAN);
    div_dividend = div_mean ? {sum, {FRAC_W{1'b0}}} : {x, {PAD_W{1'b0}}};
    div_divisor  = div_mean ? DV_W'(count) : DV_W'(d);
    div_steps    = div_mean ? ST_W'(MEAN_W) : ST_W'(VALUE_BITS);
    x_small      = (x < VALUE_BITS'(2));
    trial_end    = (sq > SQ_W'(x));
    out_free     = !out_valid || !out_stall;
    in_stall     = (state != ST_IDLE);
    sum_wide     = SE_W'(sum) + SE_W'(x);
    sum_over     = (sum_wide > SUM_LIM);
    count_full   = (count == {CNT_W{1'b1}});
  end

  pfa_divider #(
    .N_W (MEAN_W),
    .D_W (DV_W),
    .S_W (ST_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .steps     (div_steps),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (x_small || trial_end) begin
          state_next = ST_ACCUM;
        end else begin
          div_start  = 1'b1;
          state_next = ST_TRIAL;
        end
      end
      ST_TRIAL: begin
        if (div_done) state_next = (div_rem == '0) ? ST_ACCUM : ST_CHECK;
      end
      ST_ACCUM: begin
        state_next = last_r ? ST_MEAN : ST_DONE;
      end
      ST_MEAN: begin
        if (count == '0) begin
          state_next = ST_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_MEAN_WAIT;
        end
      end
      ST_MEAN_WAIT: begin
        if (div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // running set statistics and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_ACCUM && prime_r) begin
        sum   <= sum_over ? SUM_LIM[SUM_W-1:0] : sum_wide[SUM_W-1:0];
        count <= count_full ? count : count + CNT_W'(1);
        ovf   <= ovf | sum_over | count_full;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
        if (last_r) begin
          sum   <= '0;
          count <= '0;
          ovf   <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          x      <= value;
          last_r <= is_last;
          d      <= TD_W'(2);
          sq     <= SQ_W'(4);
        end
      end
      ST_CHECK: begin
        prime_r <= !x_small;
      end
      ST_TRIAL: begin
        if (div_done) begin
          if (div_rem == '0) begin
            prime_r <= 1'b0;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            d  <= d + TD_W'(1);
            sq <= sq + SQ_W'({d, 1'b1});
          end
        end
      end
      ST_ACCUM: begin
        avg_r <= '0;
        nop_r <= 1'b0;
      end
      ST_MEAN: begin
        nop_r <= (count == '0);
      end
      ST_MEAN_WAIT: begin
        if (div_done) begin
          avg_r <= (div_quo[MEAN_W-1:AVG_W] != '0) ? {AVG_W{1'b1}}
                                                   : div_quo[AVG_W-1:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          is_prime      <= prime_r;
          average_valid <= last_r;
          average       <= avg_r;
          no_primes     <= nop_r;
          saturated     <= last_r & ovf;
        end
      end
      default: begin
      end
    endcase
  end

  `PFA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `PFA_ASSERT_IMPL(a_sum_needs_count, clk, rst, count == '0, sum == '0)
  `PFA_ASSERT_IMPL(a_plain_result_clean, clk, rst, out_valid && !average_valid, average == '0 && !no_primes && !saturated)
  `PFA_ASSERT_IMPL(a_empty_set_zero, clk, rst, out_valid && no_primes, average == '0)
  `PFA_ASSERT_IMPL(a_div_done_expected, clk, rst, div_done, state == ST_TRIAL || state == ST_MEAN_WAIT)

endmodule

[design/pfa_divider.sv]
// ----------------------------------------------------------------------------
// pfa_divider
// Shared restoring divider, one quotient bit per cycle. Runs a given number
// of steps over a left-aligned dividend; done pulses when results are ready.
// ----------------------------------------------------------------------------
module pfa_divider #(
  parameter int N_W = 35,
  parameter int D_W = 11,
  parameter int S_W = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [S_W-1:0] steps,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient,
  output logic [D_W-1:0] remainder
);

  logic           busy;
  logic [S_W-1:0] cnt;
  logic [D_W-1:0] dvs;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           fits;

  always_comb begin
    trial = {remainder, quotient[N_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - S_W'(1);
        if (cnt == S_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[N_W-2:0], fits};
      remainder <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// prime_filter_average testbench
// Streams numbers in sets through the trial-division prime filter and checks
// every result item against a local prediction of the prime flag, the running
// mean of the primes, the empty-set flag and sum or count saturation. The
// sender idles in bursts and the receiver stalls on its own pattern. One long
// receiver hold-off fills the block up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pfa_pkg::*;

  localparam int VBITS      = 16;
  localparam int IDLE_LIMIT = 20000;  // cycles with no handshake on either side
  localparam int LONG_HOLD  = 3000;
  localparam int RANDOM_ITEMS = 300;
  localparam int SETTLE_CYCLES = 5000;

  typedef struct packed {
    logic             is_prime;
    logic             average_valid;
    logic [AVG_W-1:0] average;
    logic             no_primes;
    logic             saturated;
  } result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [VBITS-1:0] value = '0;
  logic             is_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             is_prime;
  logic             average_valid;
  logic [AVG_W-1:0] average;
  logic             no_primes;
  logic             saturated;

  prime_filter_average #(.VALUE_BITS(VBITS)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_prime     (is_prime),
    .average_valid(average_valid),
    .average      (average),
    .no_primes    (no_primes),
    .saturated    (saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // running state of the set, mirrored from the block
  logic [SUM_W-1:0] set_sum   = '0;
  logic [CNT_W-1:0] set_count = '0;
  logic             set_overflow = 1'b0;

  result_t pending_results[$];
  int      error_count = 0;

  // sender control
  bit offering   = 1'b0;
  int burst_left = 0;

  // receiver control
  bit hold_req   = 1'b0;

  function automatic bit trial_division_prime(logic [VBITS-1:0] v);
    int unsigned x;
    int unsigned d;
    x = v;
    if (x < 2) return 1'b0;
    for (d = 2; d * d <= x; d++) begin
      if (x % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic result_t predict_outcome(logic [VBITS-1:0] v, logic last);
    result_t           r;
    logic [SUM_W:0]    s;
    logic [MEAN_W-1:0] quo;
    r = '0;
    r.is_prime = trial_division_prime(v);
    if (r.is_prime) begin
      s = {1'b0, set_sum} + (SUM_W + 1)'(v);
      if (s[SUM_W]) begin
        set_sum = '1;
        set_overflow = 1'b1;
      end else begin
        set_sum = s[SUM_W-1:0];
      end
      if (set_count == '1) set_overflow = 1'b1;
      else set_count++;
    end
    if (last) begin
      r.average_valid = 1'b1;
      if (set_count == '0) begin
        r.no_primes = 1'b1;
      end else begin
        quo = {set_sum, {FRAC_W{1'b0}}} / MEAN_W'(set_count);
        r.average = (|quo[MEAN_W-1:AVG_W]) ? '1 : quo[AVG_W-1:0];
      end
      r.saturated  = set_overflow;
      set_sum      = '0;
      set_count    = '0;
      set_overflow = 1'b0;
    end
    return r;
  endfunction

  // one item; valid stays high into the next call unless a gap is due
  task automatic send_item(input logic [VBITS-1:0] v, input logic last);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
    end
    if (!offering && gap == 0) gap = 1;
    if (gap > 0) begin
      if (offering) in_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
      in_valid <= 1'b1;
      offering = 1'b1;
    end
    value   <= v;
    is_last <= last;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    pending_results.push_back(predict_outcome(v, last));
  endtask

  task automatic idle_sender();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
  endtask

  task automatic wait_drained();
    idle_sender();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // mostly short trial-division runs, a few across the whole 16-bit range
  function automatic logic [VBITS-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return VBITS'($urandom_range(0, 255));
    if (r < 72) return VBITS'($urandom_range(0, 4095));
    if (r < 80) return VBITS'(16'hffff - $urandom_range(0, 63));
    return VBITS'($urandom);
  endfunction

  // extremes, boundary squares, empty sets, truncated means
  task automatic test_directed();
    send_item(16'd0, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd2, 1'b0);
    send_item(16'd3, 1'b0);
    send_item(16'd4, 1'b1);       // mean of 2 and 3
    send_item(16'd0, 1'b1);       // empty set
    send_item(16'd9, 1'b0);
    send_item(16'd25, 1'b0);
    send_item(16'd49, 1'b1);      // squares of primes only
    send_item(16'd63001, 1'b0);   // 251*251, largest prime square in range
    send_item(16'hffff, 1'b0);
    send_item(16'd65521, 1'b1);   // largest 16-bit prime, last counts itself
    send_item(16'd2, 1'b0);
    send_item(16'd3, 1'b0);
    send_item(16'd5, 1'b1);       // 10/3, truncated
    send_item(16'd1, 1'b1);
    send_item(16'd7, 1'b1);       // single prime set
    send_item(16'd65521, 1'b0);
    send_item(16'd65519, 1'b0);
    send_item(16'd32768, 1'b0);
    send_item(16'd21845, 1'b1);
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    int n;
    hold_req = 1'b1;
    for (n = 0; n < 12; n++) send_item(VBITS'($urandom_range(0, 63)), n % 4 == 3);
    wait_drained();
  endtask

  task automatic test_random_sets();
    int sent;
    int len;
    int n;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = $urandom_range(20, 40);
        default: len = $urandom_range(2, 10);
      endcase
      for (n = 0; n < len; n++) send_item(pick_value(), n == len - 1);
      sent += len;
    end
    wait_drained();
  endtask

  // receiver: long hold on request, else a stall pattern that changes mode
  int hold_left = 0;
  int mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= $urandom_range(0, 1);
        2:       out_stall <= ($urandom_range(0, 9) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [AVG_W-1:0] exp_v,
                             input logic [AVG_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("is_prime", AVG_W'(exp_r.is_prime), AVG_W'(is_prime));
        check_field("average_valid", AVG_W'(exp_r.average_valid), AVG_W'(average_valid));
        check_field("average", exp_r.average, average);
        check_field("no_primes", AVG_W'(exp_r.no_primes), AVG_W'(no_primes));
        check_field("saturated", AVG_W'(exp_r.saturated), AVG_W'(saturated));
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("prime_filter_average regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_sets();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("prime_filter_average regression: pass");
    end else begin
      $display("prime_filter_average regression: fail");
    end
    $finish;
  end

endmodule

[prime_filter_average.f]
+incdir+design
design/pfa_pkg.sv
design/pfa_divider.sv
design/prime_filter_average.sv
bench/testbench.sv
